// File: src/hat_pkg.sv
package hat_pkg;

  typedef struct packed {
    logic [1:0]         func;
    logic [23:0]        key_row;
    logic [23:0]        key_col;
    logic signed [31:0] add_value;
  } hat_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] entry_value;
    logic [12:0]        entry_count;
  } hat_out_t;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  // pool size and key width are tied to the word layout above
  localparam int POOL_ENTRIES = 4096;
  localparam int KEY_BITS     = 24;

  localparam int CFG_BITS = 11;
  localparam logic [CFG_BITS-1:0] BUCKET_COUNT_RESET = 11'd1024;

endpackage

// File: src/hat_ram.sv
module hat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/hash_accumulate_table.sv
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, in_data (hat_in_t)
// out     | output    | out_valid, out_ready, out_data (hat_out_t)
// cfg     | input     | cfg_valid, cfg_ready, cfg_data (bucket_count)
//
// One item at a time. The result word is loaded after these steps, in order: two hash
// multiply steps, a remainder unit that works one quotient bit a cycle, the head read,
// a read per chain entry visited, and the table update that loads the result. The next
// item is accepted once the last one's result word is loaded, not before.
// After reset a clearing pass writes every bucket head empty, during which no item is
// accepted. The result word waits in its own register; the next item is accepted
// meanwhile and holds before its table update until that word is taken.
module hash_accumulate_table #(
  parameter int BUCKETS      = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hat_pkg::hat_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hat_pkg::hat_out_t   out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [10:0]         cfg_data
);
  import hat_pkg::*;

  localparam int BW  = $clog2(BUCKETS);
  localparam int PW  = $clog2(POOL_ENTRIES + 1);   // holds NIL
  localparam int PA  = $clog2(POOL_ENTRIES);
  localparam int KW  = 2 * KEY_BITS;
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);
  localparam logic [16:0] BUCKETS_W = 17'(BUCKETS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_HEAD  = 4'd5;
  localparam logic [3:0] S_HWAIT = 4'd6;
  localparam logic [3:0] S_ENT   = 4'd7;
  localparam logic [3:0] S_EWAIT = 4'd8;
  localparam logic [3:0] S_FREE  = 4'd9;
  localparam logic [3:0] S_FWAIT = 4'd10;
  localparam logic [3:0] S_ACT   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_CMP   = 4'd13;

  logic [3:0]  state;
  logic [10:0] bucket_count;
  hat_in_t     item;
  logic [31:0] h;
  logic [16:0] modn;
  logic [31:0] rem_acc;
  logic [5:0]  bit_cnt;
  logic [BW-1:0] bucket;
  logic [PW-1:0] cur, prev, cur_link, free_head, fresh_mark;
  logic [12:0]   stored_count;
  logic [BW:0]   clr_idx;
  logic [PW-1:0] walk_steps;
  logic signed [31:0] cur_val;
  hat_out_t      res;

  // memory ports
  logic            head_we;
  logic [BW-1:0]   head_waddr, head_raddr;
  logic [PW-1:0]   head_wdata, head_rdata;
  logic            key_we, val_we, link_we;
  logic [PA-1:0]   key_waddr, val_waddr, link_waddr, ent_raddr;
  logic [KW-1:0]   key_wdata, key_rdata;
  logic [31:0]     val_wdata, val_rdata;
  logic [PW-1:0]   link_wdata, link_rdata;

  hat_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(head_raddr), .rdata(head_rdata));
  hat_ram #(.WIDTH(KW), .DEPTH(POOL_ENTRIES)) u_keys (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(ent_raddr), .rdata(key_rdata));
  hat_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_vals (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(ent_raddr), .rdata(val_rdata));
  hat_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_links (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(ent_raddr), .rdata(link_rdata));

  logic [KW-1:0] item_key;
  logic [31:0]   row_w, col_w;
  logic [32:0]   trial;
  logic signed [32:0] sum;
  logic signed [31:0] sat_sum;

  assign row_w    = 32'(item.key_row[KEY_BITS-1:0]);
  assign col_w    = 32'(item.key_col[KEY_BITS-1:0]);
  assign item_key = {item.key_row[KEY_BITS-1:0], item.key_col[KEY_BITS-1:0]};
  assign trial    = {rem_acc, h[31]} - {16'd0, modn};
  assign sum      = 33'(cur_val) + 33'(item.add_value);
  assign sat_sum  = (sum > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                    (sum < -33'sh080000000) ? -32'sh80000000 : sum[31:0];

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_data  = res;

  // memory address and write control
  always_comb begin
    head_we = 1'b0; head_waddr = bucket; head_wdata = NIL; head_raddr = bucket;
    key_we = 1'b0; val_we = 1'b0; link_we = 1'b0;
    key_waddr = PA'(cur); val_waddr = PA'(cur); link_waddr = PA'(cur);
    key_wdata = item_key; val_wdata = sat_sum; link_wdata = NIL;
    ent_raddr = PA'(cur);
    if (state == S_CLEAR) begin
      head_we = 1'b1; head_waddr = clr_idx[BW-1:0];
    end
    if (state == S_FREE) ent_raddr = PA'(free_head);
    if (state == S_ACT) begin
      unique case (item.func)
        FUNC_INSERT: begin
          if (cur != NIL) begin
            val_we = 1'b1;
          end else begin
            if (free_head != NIL || fresh_mark != NIL) begin
              key_waddr = (free_head != NIL) ? PA'(free_head) : PA'(fresh_mark);
              val_waddr = key_waddr; link_waddr = key_waddr;
              key_we = 1'b1; val_we = 1'b1; link_we = 1'b1;
              val_wdata = item.add_value; link_wdata = head_rdata;
              head_we = 1'b1;
              head_wdata = (free_head != NIL) ? free_head : fresh_mark;
            end
          end
        end
        FUNC_REMOVE: begin
          if (cur != NIL) begin
            // unlink: cur_link is cur's successor
            if (prev != NIL) begin
              link_we = 1'b1; link_waddr = PA'(prev); link_wdata = cur_link;
            end else begin
              head_we = 1'b1; head_wdata = cur_link;
            end
          end
        end
        default: ;
      endcase
    end
    // push removed slot on the free list in the cycle after the unlink
    if (state == S_OUT && item.func == FUNC_REMOVE && res.status == ST_FOUND
        && !out_valid) begin
      link_we = 1'b1; link_waddr = PA'(cur); link_wdata = free_head;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      bucket_count <= BUCKET_COUNT_RESET;
      free_head    <= NIL;
      fresh_mark   <= '0;
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) bucket_count <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == (BW+1)'(BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            item <= in_data;
            // fold in row
            h     <= FNV_BASIS ^ 32'(in_data.key_row[KEY_BITS-1:0]);
            modn  <= (bucket_count == 11'd0) ? 17'd1 :
                     (17'(bucket_count) > BUCKETS_W) ? BUCKETS_W : 17'(bucket_count);
            state <= S_MUL1;
          end
        end
        S_MUL1: begin
          h     <= (h * FNV_PRIME) ^ col_w;
          state <= S_MUL2;
        end
        S_MUL2: begin
          h       <= h * FNV_PRIME;
          rem_acc <= '0;
          bit_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          // restoring remainder, one bit a cycle
          if (!trial[32]) rem_acc <= trial[31:0];
          else rem_acc <= {rem_acc[30:0], h[31]};
          h       <= {h[30:0], 1'b0};
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == 6'd31) state <= S_HEAD;
        end
        S_HEAD: begin
          bucket <= BW'(rem_acc);
          state  <= S_HWAIT;
        end
        S_HWAIT: begin
          // head read issued this cycle, data present next cycle
          state <= S_ENT;
        end
        S_ENT: begin
          cur        <= head_rdata;
          prev       <= NIL;
          walk_steps <= '0;
          state      <= (head_rdata == NIL) ? S_FREE : S_EWAIT;
        end
        S_EWAIT: begin
          // entry read for cur issued here, compare next cycle
          state <= S_CMP;
        end
        S_CMP: begin
          if (key_rdata == item_key) begin
            cur_val  <= val_rdata;
            cur_link <= link_rdata;
            state    <= S_FREE;
          end else begin
            prev       <= cur;
            walk_steps <= walk_steps + 1'b1;
            if (link_rdata == NIL || walk_steps == NIL - 1'b1) begin
              cur   <= NIL;
              state <= S_FREE;
            end else begin
              cur   <= link_rdata;
              state <= S_EWAIT;
            end
          end
        end
        S_FREE: begin
          // hold until the previous word has been taken
          if (!out_valid || out_ready) state <= S_FWAIT;
        end
        S_FWAIT: begin
          // free-list successor now on link_rdata; head still on head_rdata
          cur_link <= (cur == NIL) ? link_rdata : cur_link;
          state    <= S_ACT;
        end
        S_ACT: begin
          unique case (item.func)
            FUNC_INSERT: begin
              if (cur != NIL) begin
                res.status <= ST_FOUND; res.entry_value <= sat_sum;
              end else if (free_head != NIL) begin
                free_head    <= cur_link;
                stored_count <= stored_count + 1'b1;
                res.status   <= ST_INSERTED; res.entry_value <= item.add_value;
              end else if (fresh_mark != NIL) begin
                fresh_mark   <= fresh_mark + 1'b1;
                stored_count <= stored_count + 1'b1;
                res.status   <= ST_INSERTED; res.entry_value <= item.add_value;
              end else begin
                res.status <= ST_FULL; res.entry_value <= '0;
              end
            end
            FUNC_REMOVE: begin
              res.status      <= (cur != NIL) ? ST_FOUND : ST_MISSING;
              res.entry_value <= '0;
              if (cur != NIL && stored_count != 13'd0)
                stored_count <= stored_count - 1'b1;
            end
            default: begin
              res.status      <= (cur != NIL) ? ST_FOUND : ST_MISSING;
              res.entry_value <= (cur != NIL) ? cur_val : '0;
            end
          endcase
          state <= S_OUT;
        end
        S_OUT: begin
          res.entry_count <= stored_count;
          if (item.func == FUNC_REMOVE && res.status == ST_FOUND) free_head <= cur;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // pending word stays put until taken
  assert property (@(posedge clk) disable iff (rst)
                   (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("pending word changed before it was taken");
  // result appears only after the sequencer finishes
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state) == S_OUT)
    else $error("result raised outside output step");
  // count never exceeds pool size
  assert property (@(posedge clk) disable iff (rst) stored_count <= 13'(POOL_ENTRIES))
    else $error("stored count overflow");
  // allocation mark stays within pool
  assert property (@(posedge clk) disable iff (rst) fresh_mark <= NIL)
    else $error("fresh mark out of range");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import hat_pkg::*;

  localparam int NUM_BUCKETS = 1024;
  localparam int NUM_SLOTS   = 4096;
  localparam logic [12:0] NIL = 13'd4096;
  localparam int POOL_KEYS   = 32;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  hat_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  hat_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [10:0] cfg_data = '0;

  hash_accumulate_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the table
  logic [12:0]        chain_head [NUM_BUCKETS];
  logic [47:0]        slot_key   [NUM_SLOTS];
  logic signed [31:0] slot_value [NUM_SLOTS];
  logic [12:0]        slot_next  [NUM_SLOTS];
  logic [12:0]        free_list;
  logic [12:0]        next_fresh;
  logic [12:0]        live_entries;
  logic [10:0]        bucket_setting;

  hat_in_t  word_q [$];
  hat_out_t table_answers [$];

  logic [23:0] pool_row [POOL_KEYS];
  logic [23:0] pool_col [POOL_KEYS];

  int  mismatches = 0;
  int  words_sent = 0;
  int  words_checked = 0;
  int  status_seen [4];
  int  cfg_writes = 0;
  bit  in_fire = 1'b0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_cnt = 0;

  function automatic logic [31:0] bucket_index(logic [23:0] row, logic [23:0] col);
    logic [31:0] h;
    logic [31:0] n;
    n = 32'(bucket_setting);
    if (n == 0) n = 1;
    if (n > NUM_BUCKETS) n = NUM_BUCKETS;
    h = FNV_BASIS ^ {8'd0, row};
    h = h * FNV_PRIME;
    h = h ^ {8'd0, col};
    h = h * FNV_PRIME;
    return h % n;
  endfunction

  function automatic logic signed [31:0] clamp_add(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[31:0];
  endfunction

  // Apply one operation to the shadow table and return the expected word
  function automatic hat_out_t apply_op(hat_in_t it);
    hat_out_t    r;
    logic [31:0] b;
    logic [47:0] k;
    logic [12:0] cur;
    logic [12:0] prev;
    logic [12:0] slot;
    int          steps;
    r = '0;
    k = {it.key_row, it.key_col};
    b = bucket_index(it.key_row, it.key_col);
    cur = chain_head[b];
    prev = NIL;
    steps = 0;
    while (cur < NIL && steps < NUM_SLOTS) begin
      if (slot_key[cur] == k) break;
      prev = cur;
      cur = slot_next[cur];
      steps++;
    end
    if (steps >= NUM_SLOTS) cur = NIL;
    if (it.func == FUNC_INSERT) begin
      if (cur != NIL) begin
        slot_value[cur] = clamp_add(slot_value[cur], it.add_value);
        r.entry_value = slot_value[cur];
        r.status = ST_FOUND;
      end else begin
        slot = NIL;
        if (free_list < NIL) begin
          slot = free_list;
          free_list = slot_next[slot];
        end else if (next_fresh < NIL) begin
          slot = next_fresh;
          next_fresh++;
        end
        if (slot == NIL) begin
          r.status = ST_FULL;
        end else begin
          slot_key[slot] = k;
          slot_value[slot] = it.add_value;
          slot_next[slot] = chain_head[b];
          chain_head[b] = slot;
          live_entries++;
          r.entry_value = it.add_value;
          r.status = ST_INSERTED;
        end
      end
    end else if (it.func == FUNC_REMOVE) begin
      if (cur != NIL) begin
        if (prev < NIL) slot_next[prev] = slot_next[cur];
        else chain_head[b] = slot_next[cur];
        slot_next[cur] = free_list;
        free_list = cur;
        if (live_entries > 0) live_entries--;
        r.status = ST_FOUND;
      end else begin
        r.status = ST_MISSING;
      end
    end else begin
      if (cur != NIL) begin
        r.entry_value = slot_value[cur];
        r.status = ST_FOUND;
      end else begin
        r.status = ST_MISSING;
      end
    end
    r.entry_count = live_entries;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH word %0d %s: got %0h, expected %0h", words_checked, what, got, want);
  endtask

  // Check results and predict on accepted words
  always @(posedge clk) begin
    hat_out_t want;
    in_fire <= in_valid && in_ready && !rst;
    if (!rst && out_valid && out_ready) begin
      if (table_answers.size() == 0) begin
        report("unexpected word", 32'(out_data.status), 32'd0);
      end else begin
        want = table_answers.pop_front();
        if (out_data.status !== want.status)
          report("status", 32'(out_data.status), 32'(want.status));
        if (out_data.entry_value !== want.entry_value)
          report("entry_value", out_data.entry_value, want.entry_value);
        if (out_data.entry_count !== want.entry_count)
          report("entry_count", 32'(out_data.entry_count), 32'(want.entry_count));
        status_seen[want.status]++;
      end
      words_checked++;
    end
    if (!rst && in_valid && in_ready) begin
      table_answers.push_back(apply_op(in_data));
      words_sent++;
    end
  end

  // Sender: hold the word until taken, idle in random bursts
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(1, 15);
        in_valid <= 1'b0;
      end else if (word_q.size() > 0) begin
        in_data <= word_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 600;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(1, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_op(logic [1:0] f, logic [23:0] row, logic [23:0] col,
                         logic signed [31:0] v);
    hat_in_t it;
    it.func = f;
    it.key_row = row;
    it.key_col = col;
    it.add_value = v;
    word_q.push_back(it);
  endtask

  task automatic drain;
    while (word_q.size() > 0 || in_valid || table_answers.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_buckets(logic [10:0] v);
    @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    bucket_setting = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly keys from a small set so that hits and chains build up
  task automatic random_ops(int cnt);
    logic [1:0]         f;
    logic [23:0]        row;
    logic [23:0]        col;
    logic signed [31:0] v;
    int                 p;
    int                 sel;
    for (int i = 0; i < cnt; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) f = FUNC_INSERT;
      else if (sel < 75) f = FUNC_LOOKUP;
      else if (sel < 95) f = FUNC_REMOVE;
      else f = FUNC_UNUSED;
      if ($urandom_range(0, 99) < 85) begin
        p = $urandom_range(0, POOL_KEYS - 1);
        row = pool_row[p];
        col = pool_col[p];
      end else begin
        row = 24'($urandom);
        col = 24'($urandom);
      end
      sel = $urandom_range(0, 19);
      if (sel == 0) v = 32'sh7FFFFFFF;
      else if (sel == 1) v = 32'sh80000000;
      else v = $urandom;
      push_op(f, row, col, v);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_BUCKETS; i++) chain_head[i] = NIL;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    free_list = NIL;
    next_fresh = '0;
    live_entries = '0;
    bucket_setting = BUCKET_COUNT_RESET;
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_row[i] = (i < 4) ? 24'(i) : 24'($urandom);
      pool_col[i] = (i < 4) ? 24'hFFFFFF : 24'($urandom);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: saturation both ways, misses, slot reuse, unused code
    push_op(FUNC_LOOKUP, 24'h0, 24'h0, 32'sh0);
    push_op(FUNC_INSERT, 24'h0, 24'h0, 32'sh7FFFFFFF);
    push_op(FUNC_INSERT, 24'h0, 24'h0, 32'sh1);
    push_op(FUNC_LOOKUP, 24'h0, 24'h0, 32'sh0);
    push_op(FUNC_INSERT, 24'hFFFFFF, 24'hFFFFFF, 32'sh80000000);
    push_op(FUNC_INSERT, 24'hFFFFFF, 24'hFFFFFF, 32'sh80000000);
    push_op(FUNC_UNUSED, 24'hFFFFFF, 24'hFFFFFF, 32'sh0);
    push_op(FUNC_INSERT, 24'h0, 24'h0, 32'sh80000000);
    push_op(FUNC_REMOVE, 24'h0, 24'h0, 32'sh0);
    push_op(FUNC_LOOKUP, 24'h0, 24'h0, 32'sh0);
    push_op(FUNC_REMOVE, 24'h0, 24'h0, 32'sh0);
    push_op(FUNC_INSERT, 24'h0, 24'hFFFFFF, 32'sh0);
    push_op(FUNC_REMOVE, 24'hFFFFFF, 24'hFFFFFF, 32'sh0);
    push_op(FUNC_INSERT, 24'hABCDEF, 24'h123456, 32'sh00018000);
    push_op(FUNC_INSERT, 24'hABCDEF, 24'h123456, 32'shFFFF0000);
    push_op(FUNC_UNUSED, 24'h0, 24'h0, 32'sh0);
    drain();

    // Walk through bucket settings, extremes first
    write_buckets(11'd1);
    random_ops(150);
    drain();
    write_buckets(11'd0);
    random_ops(100);
    drain();
    write_buckets(11'd2047);
    hold_req = 1'b1;
    random_ops(150);
    drain();
    write_buckets(11'($urandom_range(2, 1023)));
    random_ops(150);
    drain();
    quiet = 1'b1;
    write_buckets(11'd1024);
    random_ops(200);
    drain();

    // Free a few slots, then reuse them
    for (int i = 0; i < 20; i++)
      push_op(FUNC_REMOVE, pool_row[i], pool_col[i], 32'sh0);
    random_ops(60);
    drain();

    $display("Sent %0d words over %0d bucket settings, checked %0d results",
             words_sent, cfg_writes, words_checked);
    $display("Status mix: found %0d, inserted %0d, missing %0d, full %0d",
             status_seen[ST_FOUND], status_seen[ST_INSERTED],
             status_seen[ST_MISSING], status_seen[ST_FULL]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
